// ----- rtl/mma_pkg.sv -----
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types, constants and helpers of the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

    // Fixed field widths
    localparam int IDX_W      = 3;   // row / column index fields
    localparam int DIM_REG_W  = 4;   // dimension registers
    localparam int CFG_IDX_W  = 3;   // configuration register index
    localparam int CFG_DATA_W = 4;   // configuration write data
    localparam int OP_W       = 2;   // opcode field
    localparam int ACC_W      = 40;  // result value
    localparam int OUT_DATA_W = 48;  // row + col + value, padded to bytes
    localparam int OUT_PAD_W  = OUT_DATA_W - 2 * IDX_W - ACC_W;

    // Parameter defaults
    localparam int DEFAULT_MAX_DIM     = 8;
    localparam int DEFAULT_VALUE_WIDTH = 16;

    // Reset value of the dimension registers
    localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

    // Request kinds on the input stream
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_LOAD_D  = 2'd2,
        OP_COMPUTE = 2'd3
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS  = 3'd0,
        CFG_A_COLS  = 3'd1,
        CFG_B_ROWS  = 3'd2,
        CFG_B_COLS  = 3'd3,
        CFG_ADD_EN  = 3'd4
    } cfg_reg_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MAC  = 2'd1,
        ST_WAIT = 2'd2
    } mma_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_a;      // write matrix A store
        logic             wr_b;      // write matrix B store
        logic             wr_d;      // write addend store
        logic             issue;     // one multiply term enters the pipeline
        logic             first;     // first term of a result element
        logic             last_k;    // final term of a result element
        logic             add_en;    // add the addend element
        logic             load_out;  // move finished sum into output register
        logic [IDX_W-1:0] out_row;
        logic [IDX_W-1:0] out_col;
        logic             out_last;
    } mma_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic acc_ready;  // finished sum waiting in the accumulator
        logic out_free;   // output register can take a result this cycle
    } mma_status_t;

    // Dimension of 0 acts as 1, above the store size acts as the store size
    function automatic logic [DIM_REG_W-1:0] clamp_dim(
        input logic [DIM_REG_W-1:0] d,
        input logic [DIM_REG_W-1:0] max_dim
    );
        logic [DIM_REG_W-1:0] r;
        if (d == '0)
            r = DIM_REG_W'(1);
        else if (d > max_dim)
            r = max_dim;
        else
            r = d;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mma_ctrl.sv -----
// ----------------------------------------------------------------------------
// mma_ctrl
// Controller: configuration registers, request decode and the i/j/k sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_ctrl #(
    parameter int MAX_DIM = mma_pkg::DEFAULT_MAX_DIM
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mma_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mma_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input request handshake and decoded fields
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire mma_pkg::opcode_t                 opcode,
    input  wire logic [mma_pkg::IDX_W-1:0]        row_index,
    input  wire logic [mma_pkg::IDX_W-1:0]        col_index,
    // datapath interface
    output mma_pkg::mma_cmd_t                     cmd,
    input  wire mma_pkg::mma_status_t             status,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    wr_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    rd_a_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    rd_b_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    rd_d_addr
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int DIM_W = $clog2(MAX_DIM);
    localparam logic [mma_pkg::DIM_REG_W-1:0] MAX_DIM_V = mma_pkg::DIM_REG_W'(MAX_DIM);

    mma_pkg::mma_state_t state_reg, state_next;

    logic [mma_pkg::DIM_REG_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic                          add_en_reg;

    logic [DIM_W-1:0] i_reg, i_next;
    logic [DIM_W-1:0] j_reg, j_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic [DIM_W-1:0] rows_last_reg, rows_last_next;
    logic [DIM_W-1:0] cols_last_reg, cols_last_next;
    logic [DIM_W-1:0] inner_last_reg, inner_last_next;

    logic [mma_pkg::DIM_REG_W-1:0] rows_c, cols_c, ac_c, br_c, inner_c;
    logic                          load_in_range;

    // Configuration registers; writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= mma_pkg::DIM_RESET;
            a_cols_reg <= mma_pkg::DIM_RESET;
            b_rows_reg <= mma_pkg::DIM_RESET;
            b_cols_reg <= mma_pkg::DIM_RESET;
            add_en_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (mma_pkg::cfg_reg_t'(cfg_index))
                mma_pkg::CFG_A_ROWS: a_rows_reg <= cfg_data;
                mma_pkg::CFG_A_COLS: a_cols_reg <= cfg_data;
                mma_pkg::CFG_B_ROWS: b_rows_reg <= cfg_data;
                mma_pkg::CFG_B_COLS: b_cols_reg <= cfg_data;
                mma_pkg::CFG_ADD_EN: add_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective dimensions
    always_comb
    begin
        rows_c  = mma_pkg::clamp_dim(a_rows_reg, MAX_DIM_V);
        cols_c  = mma_pkg::clamp_dim(b_cols_reg, MAX_DIM_V);
        ac_c    = mma_pkg::clamp_dim(a_cols_reg, MAX_DIM_V);
        br_c    = mma_pkg::clamp_dim(b_rows_reg, MAX_DIM_V);
        inner_c = (ac_c < br_c) ? ac_c : br_c;
    end

    // Store addresses
    assign load_in_range = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
    assign wr_addr   = AW'(int'(row_index) * MAX_DIM + int'(col_index));
    assign rd_a_addr = AW'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign rd_b_addr = AW'(int'(k_reg) * MAX_DIM + int'(j_reg));
    assign rd_d_addr = AW'(int'(i_reg) * MAX_DIM + int'(j_reg));

    // State and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mma_pkg::ST_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            rows_last_reg  <= '0;
            cols_last_reg  <= '0;
            inner_last_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            rows_last_reg  <= rows_last_next;
            cols_last_reg  <= cols_last_next;
            inner_last_reg <= inner_last_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        rows_last_next  = rows_last_reg;
        cols_last_next  = cols_last_reg;
        inner_last_next = inner_last_reg;
        s_tready        = 1'b0;

        cmd          = '0;
        cmd.add_en   = add_en_reg;
        cmd.first    = (k_reg == '0);
        cmd.last_k   = (k_reg == inner_last_reg);
        cmd.out_row  = mma_pkg::IDX_W'(i_reg);
        cmd.out_col  = mma_pkg::IDX_W'(j_reg);
        cmd.out_last = (i_reg == rows_last_reg) && (j_reg == cols_last_reg);

        unique case (state_reg)
            mma_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (opcode)
                        mma_pkg::OP_LOAD_A: cmd.wr_a = load_in_range;
                        mma_pkg::OP_LOAD_B: cmd.wr_b = load_in_range;
                        mma_pkg::OP_LOAD_D: cmd.wr_d = load_in_range;
                        mma_pkg::OP_COMPUTE:
                        begin
                            state_next      = mma_pkg::ST_MAC;
                            i_next          = '0;
                            j_next          = '0;
                            k_next          = '0;
                            rows_last_next  = DIM_W'(rows_c - 1'b1);
                            cols_last_next  = DIM_W'(cols_c - 1'b1);
                            inner_last_next = DIM_W'(inner_c - 1'b1);
                        end
                        default: ;
                    endcase
                end
            end

            // one multiply term per cycle
            mma_pkg::ST_MAC:
            begin
                cmd.issue = 1'b1;
                if (k_reg == inner_last_reg)
                begin
                    k_next     = '0;
                    state_next = mma_pkg::ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            // hand the finished sum to the output register, then next element or idle after the last
            mma_pkg::ST_WAIT:
            begin
                if (status.acc_ready && status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (cmd.out_last)
                    begin
                        state_next = mma_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = mma_pkg::ST_MAC;
                        if (j_reg == cols_last_reg)
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end

            default: state_next = mma_pkg::ST_IDLE;
        endcase
    end

    // Assertions
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mma_pkg::ST_MAC) |-> (k_reg <= inner_last_reg))
        else $error("inner counter ran past the inner dimension");

    a_ij_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mma_pkg::ST_IDLE) |->
            ((i_reg <= rows_last_reg) && (j_reg <= cols_last_reg)))
        else $error("element counters ran past the result size");

    a_no_load_during_mac: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !(cmd.wr_a || cmd.wr_b || cmd.wr_d))
        else $error("store write while terms are being read");

endmodule

`default_nettype wire

// ----- rtl/mma_datapath.sv -----
// ----------------------------------------------------------------------------
// mma_datapath
// Element stores, multiply-accumulate pipeline and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_datapath #(
    parameter int MAX_DIM     = mma_pkg::DEFAULT_MAX_DIM,
    parameter int VALUE_WIDTH = mma_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire mma_pkg::mma_cmd_t                     cmd,
    output mma_pkg::mma_status_t                       status,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    wr_addr,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    rd_a_addr,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    rd_b_addr,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    rd_d_addr,
    input  wire logic [VALUE_WIDTH-1:0]                wr_data,
    // result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [mma_pkg::OUT_DATA_W-1:0]             m_tdata,
    output logic                                       m_tlast
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int FRAC   = VALUE_WIDTH / 2;
    localparam int PROD_W = 2 * VALUE_WIDTH;
    localparam int EXT_W  = (PROD_W > mma_pkg::ACC_W) ? PROD_W : mma_pkg::ACC_W;

    // Element stores
    logic [VALUE_WIDTH-1:0] mem_a [DEPTH];
    logic [VALUE_WIDTH-1:0] mem_b [DEPTH];
    logic [VALUE_WIDTH-1:0] mem_d [DEPTH];

    // Stage 1: read data
    logic signed [VALUE_WIDTH-1:0] s1_a_reg, s1_b_reg, s1_d_reg;
    logic                          s1_valid_reg, s1_first_reg, s1_last_reg;

    // Stage 2: product
    logic signed [PROD_W-1:0]      s2_prod_reg;
    logic signed [VALUE_WIDTH-1:0] s2_d_reg;
    logic                          s2_valid_reg, s2_first_reg, s2_last_reg;

    // Stage 3: accumulator
    logic [mma_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic                          acc_ready_reg;

    // Output register
    logic                          out_valid_reg;
    logic [mma_pkg::IDX_W-1:0]     out_row_reg, out_col_reg;
    logic [mma_pkg::ACC_W-1:0]     out_value_reg;
    logic                          out_last_reg;

    logic signed [EXT_W-1:0]          prod_wide;
    logic signed [mma_pkg::ACC_W-1:0] addend_wide;
    logic [mma_pkg::ACC_W-1:0]        addend_term;

    // Store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
            mem_a[wr_addr] <= wr_data;
        if (cmd.wr_b)
            mem_b[wr_addr] <= wr_data;
        if (cmd.wr_d)
            mem_d[wr_addr] <= wr_data;
        s1_a_reg <= mem_a[rd_a_addr];
        s1_b_reg <= mem_b[rd_b_addr];
        s1_d_reg <= mem_d[rd_d_addr];
    end

    // Multiply stage
    always_ff @(posedge clk)
    begin
        s2_prod_reg <= s1_a_reg * s1_b_reg;
        s2_d_reg    <= s1_d_reg;
    end

    // Accumulate: first term starts from the shifted addend when enabled, else from zero
    always_comb
    begin
        prod_wide   = EXT_W'(s2_prod_reg);
        addend_wide = mma_pkg::ACC_W'(s2_d_reg);
        addend_term = cmd.add_en ? mma_pkg::ACC_W'(addend_wide <<< FRAC) : '0;
        if (s2_first_reg)
            acc_next = prod_wide[mma_pkg::ACC_W-1:0] + addend_term;
        else
            acc_next = acc_reg + prod_wide[mma_pkg::ACC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
            acc_reg <= acc_next;
        if (cmd.load_out)
        begin
            out_row_reg   <= cmd.out_row;
            out_col_reg   <= cmd.out_col;
            out_value_reg <= acc_reg;
            out_last_reg  <= cmd.out_last;
        end
    end

    // Pipeline tags and handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_first_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_first_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            acc_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s1_first_reg <= cmd.first;
            s1_last_reg  <= cmd.last_k;
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;

            if (s2_valid_reg && s2_last_reg)
                acc_ready_reg <= 1'b1;
            else if (cmd.load_out)
                acc_ready_reg <= 1'b0;

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.acc_ready = acc_ready_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{mma_pkg::OUT_PAD_W{1'b0}}, out_value_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

    // Assertions
    a_load_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> acc_ready_reg)
        else $error("output loaded before the sum was complete");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");

    a_sum_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_last_reg) |-> !acc_ready_reg)
        else $error("new sum finished while previous one still waiting");

endmodule

`default_nettype wire

// ----- rtl/matrix_multiply_accumulate.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// Fixed-point matrix multiply with optional addend, streamed requests/results.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one request per handshake. s_tuser carries the opcode
//   (load A, load B, load addend, compute); s_tdata carries row, column and
//   the signed element value. Loads can follow back to back. Loads with a
//   row or column outside the store are dropped.
//   A compute request emits every element of A*B (+ addend << FRAC when
//   enabled) on the output stream in row-major order, m_tlast on the final
//   one. Each element sums inner terms (inner = min(a_cols, b_rows)), issued
//   in turn to the single multiplier (store read); the products are
//   accumulated and the sum is handed off into the output register.
//   s_tready stays low from the compute request until the last result has
//   entered the output register.
//   Configuration (cfg_*) is always ready; write it only while idle.
//   A receiver stall holds the output register and pauses the sequencer at its next hand-off.
//   Reset sets all dimensions to 8 and clears the addend enable. The element
//   stores are not cleared; only loaded entries may be used.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_accumulate #(
    parameter int MAX_DIM     = mma_pkg::DEFAULT_MAX_DIM,
    parameter int VALUE_WIDTH = mma_pkg::DEFAULT_VALUE_WIDTH,
    localparam int IN_DATA_W  = ((2 * mma_pkg::IDX_W + VALUE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mma_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mma_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [IN_DATA_W-1:0]             s_tdata,   // row_index, col_index, element_value
    input  wire logic [mma_pkg::OP_W-1:0]         s_tuser,   // opcode
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [mma_pkg::OUT_DATA_W-1:0]        m_tdata,   // out_row, out_col, product_value
    output logic                                  m_tlast
);

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    mma_pkg::mma_cmd_t    cmd;
    mma_pkg::mma_status_t status;

    logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr, rd_d_addr;

    logic [mma_pkg::IDX_W-1:0] row_index, col_index;
    logic [VALUE_WIDTH-1:0]    element_value;

    // Request field unpacking
    assign row_index     = s_tdata[mma_pkg::IDX_W-1:0];
    assign col_index     = s_tdata[2*mma_pkg::IDX_W-1:mma_pkg::IDX_W];
    assign element_value = s_tdata[2*mma_pkg::IDX_W +: VALUE_WIDTH];

    mma_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .opcode    (mma_pkg::opcode_t'(s_tuser)),
        .row_index (row_index),
        .col_index (col_index),
        .cmd       (cmd),
        .status    (status),
        .wr_addr   (wr_addr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_d_addr (rd_d_addr)
    );

    mma_datapath #(
        .MAX_DIM     (MAX_DIM),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .wr_addr   (wr_addr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_d_addr (rd_d_addr),
        .wr_data   (element_value),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ----- tb/sv/matrix_multiply_accumulate_test.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_test
// Self-checking bench for the fixed-point matrix multiply-accumulate block.
// A short directed table runs first: 1x1 extremes with hand-computed results,
// then a 2x2 case. A random mix of loads, computes and register changes
// follows. All other results are checked against a local model of the
// block's arithmetic. Both stream sides see random gaps and stalls.
// ----------------------------------------------------------------------------

module matrix_multiply_accumulate_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W       = mma_pkg::IDX_W;
    localparam int ACC_W       = mma_pkg::ACC_W;
    localparam int CFG_IDX_W   = mma_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = mma_pkg::CFG_DATA_W;
    localparam int DIM_REG_W   = mma_pkg::DIM_REG_W;
    localparam int OP_W        = mma_pkg::OP_W;
    localparam int OUT_DATA_W  = mma_pkg::OUT_DATA_W;
    localparam int STORE_DIM   = mma_pkg::DEFAULT_MAX_DIM;
    localparam int VALUE_W     = mma_pkg::DEFAULT_VALUE_WIDTH;
    localparam int FRAC_W      = VALUE_W / 2;
    localparam int IN_W        = ((2 * IDX_W + VALUE_W + 7) / 8) * 8;
    localparam int ITEM_TARGET = 500;
    localparam int DRAIN       = 16;
    localparam int MAX_REPORTS = 10;

    // One expected or observed result element
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [ACC_W-1:0] value;
        logic             last;
    } mac_result_t;

    // Directed table entry: a register write or a request
    typedef enum logic {STEP_REG, STEP_REQ} step_kind_t;

    typedef struct {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DIM_REG_W-1:0] reg_val;
        mma_pkg::opcode_t     op;
        logic [IDX_W-1:0]     r;
        logic [IDX_W-1:0]     c;
        logic [VALUE_W-1:0]   v;
        bit                   typed;
        logic [ACC_W-1:0]     want;
    } step_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata   = '0;
    logic [OP_W-1:0]        s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;

    // Model state: element stores, which entries were loaded, registers
    logic [VALUE_W-1:0]     a_elem [STORE_DIM*STORE_DIM];
    logic [VALUE_W-1:0]     b_elem [STORE_DIM*STORE_DIM];
    logic [VALUE_W-1:0]     d_elem [STORE_DIM*STORE_DIM];
    bit                     a_loaded [STORE_DIM*STORE_DIM];
    bit                     b_loaded [STORE_DIM*STORE_DIM];
    bit                     d_loaded [STORE_DIM*STORE_DIM];
    logic [DIM_REG_W-1:0]   dim_a_rows = mma_pkg::DIM_RESET;
    logic [DIM_REG_W-1:0]   dim_a_cols = mma_pkg::DIM_RESET;
    logic [DIM_REG_W-1:0]   dim_b_rows = mma_pkg::DIM_RESET;
    logic [DIM_REG_W-1:0]   dim_b_cols = mma_pkg::DIM_RESET;
    logic                   addend_on  = 1'b0;

    mac_result_t            pending_products[$];
    step_t                  plan[$];
    int                     mismatch_count = 0;
    int                     items_sent     = 0;
    int                     phase_count    = 0;
    bit                     calm           = 1'b0;

    matrix_multiply_accumulate uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end

    // Effective dimension: 0 counts as 1, oversize counts as the store size
    function automatic int eff_dim(logic [DIM_REG_W-1:0] d);
        int n;
        n = d;
        if (n < 1)
            n = 1;
        else if (n > STORE_DIM)
            n = STORE_DIM;
        return n;
    endfunction

    // Idle cycles before a request; none during calm stretches
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 9);
        if (calm || roll < 6)
            return 0;
        else if (roll < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 30);
        return $urandom_range(1, 3);
    endfunction

    // Element value with extra weight on the extremes
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_REG_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return DIM_REG_W'($urandom_range(1, 3));
        else if (roll < 85)
            return DIM_REG_W'($urandom_range(4, 8));
        else if (roll < 93)
            return '0;
        return DIM_REG_W'($urandom_range(9, 15));
    endfunction

    // Store one loaded element
    function automatic void store_element(mma_pkg::opcode_t op, logic [IDX_W-1:0] r,
                                          logic [IDX_W-1:0] c, logic [VALUE_W-1:0] v);
        int slot;
        slot = r * STORE_DIM + c;
        case (op)
            mma_pkg::OP_LOAD_A:
            begin
                a_elem[slot]   = v;
                a_loaded[slot] = 1'b1;
            end
            mma_pkg::OP_LOAD_B:
            begin
                b_elem[slot]   = v;
                b_loaded[slot] = 1'b1;
            end
            mma_pkg::OP_LOAD_D:
            begin
                d_elem[slot]   = v;
                d_loaded[slot] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Expected result matrix of a compute request, row-major
    function automatic void predict_products();
        int                      rows, cols, inner, i, j, k;
        logic signed [ACC_W-1:0] sum, x, y, addend;
        mac_result_t             res;
        rows  = eff_dim(dim_a_rows);
        cols  = eff_dim(dim_b_cols);
        inner = eff_dim(dim_a_cols);
        if (eff_dim(dim_b_rows) < inner)
            inner = eff_dim(dim_b_rows);
        for (i = 0; i < rows; i++)
        begin
            for (j = 0; j < cols; j++)
            begin
                sum = '0;
                for (k = 0; k < inner; k++)
                begin
                    x = $signed(a_elem[i * STORE_DIM + k]);
                    y = $signed(b_elem[k * STORE_DIM + j]);
                    sum += x * y;
                end
                if (addend_on)
                begin
                    addend = $signed(d_elem[i * STORE_DIM + j]);
                    sum += addend <<< FRAC_W;
                end
                res.row   = IDX_W'(i);
                res.col   = IDX_W'(j);
                res.value = sum;
                res.last  = (i == rows - 1) && (j == cols - 1);
                pending_products.push_back(res);
            end
        end
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_REG_W-1:0] val);
        case (idx)
            mma_pkg::CFG_A_ROWS: dim_a_rows = val;
            mma_pkg::CFG_A_COLS: dim_a_cols = val;
            mma_pkg::CFG_B_ROWS: dim_b_rows = val;
            mma_pkg::CFG_B_COLS: dim_b_cols = val;
            mma_pkg::CFG_ADD_EN: addend_on  = val[0];
            default: ;
        endcase
    endfunction

    // Directed table builders
    function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_REG_W-1:0] val);
        step_t s;
        s.kind    = STEP_REG;
        s.reg_idx = idx;
        s.reg_val = val;
        s.op      = mma_pkg::OP_LOAD_A;
        s.r       = '0;
        s.c       = '0;
        s.v       = '0;
        s.typed   = 1'b0;
        s.want    = '0;
        plan.push_back(s);
    endfunction

    function automatic void plan_req(mma_pkg::opcode_t op, logic [IDX_W-1:0] r,
                                     logic [IDX_W-1:0] c, logic [VALUE_W-1:0] v,
                                     bit typed, logic [ACC_W-1:0] want);
        step_t s;
        s.kind    = STEP_REQ;
        s.reg_idx = '0;
        s.reg_val = '0;
        s.op      = op;
        s.r       = r;
        s.c       = c;
        s.v       = v;
        s.typed   = typed;
        s.want    = want;
        plan.push_back(s);
    endfunction

    // Send one request; s_tvalid is only lowered when a gap precedes it
    task automatic send_request(mma_pkg::opcode_t op, logic [IDX_W-1:0] r,
                                logic [IDX_W-1:0] c, logic [VALUE_W-1:0] v, int gap,
                                bit typed, logic [ACC_W-1:0] want);
        mac_result_t res;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_W'({v, c, r});
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (op != mma_pkg::OP_COMPUTE)
            store_element(op, r, c, v);
        else if (typed)
        begin
            res.row   = '0;
            res.col   = '0;
            res.value = want;
            res.last  = 1'b1;
            pending_products.push_back(res);
        end
        else
            predict_products();
    endtask

    // Stop requests and let the block drain completely
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_REG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // Load any operand entry the next compute will read but was never written
    task automatic fill_operands();
        int rows, cols, inner, i, j;
        rows  = eff_dim(dim_a_rows);
        cols  = eff_dim(dim_b_cols);
        inner = eff_dim(dim_a_cols);
        if (eff_dim(dim_b_rows) < inner)
            inner = eff_dim(dim_b_rows);
        for (i = 0; i < rows; i++)
            for (j = 0; j < inner; j++)
                if (!a_loaded[i * STORE_DIM + j])
                    send_request(mma_pkg::OP_LOAD_A, IDX_W'(i), IDX_W'(j), pick_value(),
                                 pick_gap(), 1'b0, '0);
        for (i = 0; i < inner; i++)
            for (j = 0; j < cols; j++)
                if (!b_loaded[i * STORE_DIM + j])
                    send_request(mma_pkg::OP_LOAD_B, IDX_W'(i), IDX_W'(j), pick_value(),
                                 pick_gap(), 1'b0, '0);
        if (addend_on)
            for (i = 0; i < rows; i++)
                for (j = 0; j < cols; j++)
                    if (!d_loaded[i * STORE_DIM + j])
                        send_request(mma_pkg::OP_LOAD_D, IDX_W'(i), IDX_W'(j),
                                     pick_value(), pick_gap(), 1'b0, '0);
    endtask

    // New register setting between phases; one phase runs at full size
    task automatic reconfigure();
        wait_idle();
        phase_count++;
        if (phase_count == 3)
        begin
            write_reg(mma_pkg::CFG_A_ROWS, 4'd8);
            write_reg(mma_pkg::CFG_A_COLS, 4'd15);
            write_reg(mma_pkg::CFG_B_ROWS, 4'd8);
            write_reg(mma_pkg::CFG_B_COLS, 4'd8);
            write_reg(mma_pkg::CFG_ADD_EN, 4'd1);
        end
        else
        begin
            if ($urandom_range(0, 1) == 0)
                write_reg(mma_pkg::CFG_A_ROWS, pick_dim());
            if ($urandom_range(0, 1) == 0)
                write_reg(mma_pkg::CFG_A_COLS, pick_dim());
            if ($urandom_range(0, 1) == 0)
                write_reg(mma_pkg::CFG_B_ROWS, pick_dim());
            if ($urandom_range(0, 1) == 0)
                write_reg(mma_pkg::CFG_B_COLS, pick_dim());
            // add enable only looks at bit 0
            write_reg(mma_pkg::CFG_ADD_EN, DIM_REG_W'($urandom));
            // unmapped index, must change nothing
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_IDX_W'(mma_pkg::CFG_ADD_EN) + CFG_IDX_W'($urandom_range(1, 3)),
                          DIM_REG_W'($urandom));
        end
    endtask

    // Alternate stretches with and without idling
    initial
    begin : calm_phases
        forever
        begin
            repeat ($urandom_range(150, 400)) @(posedge clk);
            calm <= ($urandom_range(0, 2) == 0);
        end
    end

    // Receiver stalls
    initial
    begin : receiver_stalls
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                hold = pick_stall() - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Result checker
    initial
    begin : result_checker
        mac_result_t got, want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.row   = m_tdata[IDX_W-1:0];
                got.col   = m_tdata[2*IDX_W-1:IDX_W];
                got.value = m_tdata[2*IDX_W +: ACC_W];
                got.last  = m_tlast;
                if (pending_products.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: row %0d col %0d value %h last %b",
                                 got.row, got.col, got.value, got.last);
                end
                else
                begin
                    want = pending_products.pop_front();
                    if (got.row != want.row || got.col != want.col ||
                        got.value != want.value || got.last != want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"mismatch: want r%0d c%0d %h last %b, ",
                                      "got r%0d c%0d %h last %b"},
                                     want.row, want.col, want.value, want.last,
                                     got.row, got.col, got.value, got.last);
                    end
                end
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int               i;
        int               roll;
        mma_pkg::opcode_t op;

        for (i = 0; i < STORE_DIM * STORE_DIM; i++)
        begin
            a_elem[i]   = '0;
            b_elem[i]   = '0;
            d_elem[i]   = '0;
            a_loaded[i] = 1'b0;
            b_loaded[i] = 1'b0;
            d_loaded[i] = 1'b0;
        end

        // 1x1 extremes: zero dimensions act as one; compute ignores its fields
        plan_reg(mma_pkg::CFG_A_ROWS, 4'd0);
        plan_reg(mma_pkg::CFG_A_COLS, 4'd1);
        plan_reg(mma_pkg::CFG_B_ROWS, 4'd0);
        plan_reg(mma_pkg::CFG_B_COLS, 4'd1);
        plan_reg(mma_pkg::CFG_ADD_EN, 4'd0);
        plan_req(mma_pkg::OP_LOAD_A,  3'd0, 3'd0, 16'h7FFF, 1'b0, '0);
        plan_req(mma_pkg::OP_LOAD_B,  3'd0, 3'd0, 16'h7FFF, 1'b0, '0);
        plan_req(mma_pkg::OP_COMPUTE, 3'd7, 3'd7, 16'hFFFF, 1'b1, 40'h003FFF0001);
        plan_req(mma_pkg::OP_LOAD_A,  3'd0, 3'd0, 16'h8000, 1'b0, '0);
        plan_req(mma_pkg::OP_LOAD_B,  3'd0, 3'd0, 16'h8000, 1'b0, '0);
        plan_req(mma_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 40'h0040000000);
        plan_req(mma_pkg::OP_LOAD_B,  3'd0, 3'd0, 16'h7FFF, 1'b0, '0);
        plan_req(mma_pkg::OP_COMPUTE, 3'd5, 3'd2, 16'h1234, 1'b1, 40'hFFC0008000);
        // addend enabled, most negative and most positive addend
        plan_req(mma_pkg::OP_LOAD_D,  3'd0, 3'd0, 16'h8000, 1'b0, '0);
        plan_reg(mma_pkg::CFG_ADD_EN, 4'd1);
        plan_req(mma_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 40'hFFBF808000);
        plan_req(mma_pkg::OP_LOAD_A,  3'd0, 3'd0, 16'h7FFF, 1'b0, '0);
        plan_req(mma_pkg::OP_LOAD_D,  3'd0, 3'd0, 16'h7FFF, 1'b0, '0);
        plan_req(mma_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 40'h00407EFF01);
        plan_req(mma_pkg::OP_LOAD_A,  3'd0, 3'd0, 16'h0000, 1'b0, '0);
        plan_req(mma_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 40'h00007FFF00);
        // 2x2 result; oversize a_cols, inner sum limited by b_rows
        plan_reg(mma_pkg::CFG_A_ROWS, 4'd2);
        plan_reg(mma_pkg::CFG_A_COLS, 4'd15);
        plan_reg(mma_pkg::CFG_B_ROWS, 4'd2);
        plan_reg(mma_pkg::CFG_B_COLS, 4'd2);
        plan_req(mma_pkg::OP_LOAD_A,  3'd0, 3'd0, 16'hFFFF, 1'b0, '0);
        plan_req(mma_pkg::OP_LOAD_A,  3'd0, 3'd1, 16'h0100, 1'b0, '0);
        plan_req(mma_pkg::OP_LOAD_A,  3'd1, 3'd0, 16'hFF00, 1'b0, '0);
        plan_req(mma_pkg::OP_LOAD_A,  3'd1, 3'd1, 16'h8000, 1'b0, '0);
        plan_req(mma_pkg::OP_LOAD_B,  3'd0, 3'd1, 16'h4000, 1'b0, '0);
        plan_req(mma_pkg::OP_LOAD_B,  3'd1, 3'd0, 16'hC000, 1'b0, '0);
        plan_req(mma_pkg::OP_LOAD_B,  3'd1, 3'd1, 16'h7FFF, 1'b0, '0);
        plan_req(mma_pkg::OP_LOAD_D,  3'd0, 3'd1, 16'h0001, 1'b0, '0);
        plan_req(mma_pkg::OP_LOAD_D,  3'd1, 3'd0, 16'hFFFF, 1'b0, '0);
        plan_req(mma_pkg::OP_LOAD_D,  3'd1, 3'd1, 16'h1234, 1'b0, '0);
        plan_req(mma_pkg::OP_COMPUTE, 3'd3, 3'd6, 16'h5A5A, 1'b0, '0);

        // Reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_REG)
            begin
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send_request(plan[i].op, plan[i].r, plan[i].c, plan[i].v, pick_gap(),
                             plan[i].typed, plan[i].want);
        end

        // Random loads and computes with register changes between phases
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 24) == 0)
                reconfigure();
            roll = $urandom_range(0, 99);
            if (roll < 14)
            begin
                fill_operands();
                send_request(mma_pkg::OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom),
                             VALUE_W'($urandom), pick_gap(), 1'b0, '0);
            end
            else
            begin
                if (roll < 43)
                    op = mma_pkg::OP_LOAD_A;
                else if (roll < 72)
                    op = mma_pkg::OP_LOAD_B;
                else
                    op = mma_pkg::OP_LOAD_D;
                send_request(op, IDX_W'($urandom), IDX_W'($urandom), pick_value(),
                             pick_gap(), 1'b0, '0);
            end
        end

        wait_idle();
        if (mismatch_count == 0 && pending_products.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
